[sv/css_pkg.sv]
// Shared widths and the job type for the cosine similarity stream.
package css_pkg;
	localparam int ELEM_W = 16;
	localparam int DOT_W  = 42;
	localparam int NORM_W = 41;
	localparam int MUL_W  = 21;
	localparam int PROD_W = 2 * DOT_W;
	localparam int P_W    = 2 * NORM_W;
	localparam int DIV_W  = 32;
	localparam int ROOT_W = 16;
	localparam int SIM_W  = 16;

	typedef struct packed {
		logic signed [DOT_W-1:0] dot;
		logic [NORM_W-1:0]       norm_a;
		logic [NORM_W-1:0]       norm_b;
	} css_job_t;
endpackage

[sv/cosine_similarity_stream.sv]
// Top level of the streaming cosine similarity block.
//
//  channel | signals                                   | handshake
//  --------+-------------------------------------------+------------------
//  in      | elem_a[15:0] elem_b[15:0] last            | in_valid/in_ready
//  out     | similarity[15:0] zero_norm                | out_valid/out_ready
//
// A pair that is not last is added into the registered sums, so pairs stream at one per
// cycle while no result is being computed. A last pair with nonzero norms starts the
// engine: 4 + 4 steps on a shared 21x21 multiplier, 1 check, 32 division steps (none
// when the quotient saturates), 16 root steps and a finish step; in_ready stays low
// until the result is registered. A zero-norm last pair gives its result the next
// cycle; a last pair waits while an earlier result sits in the output register.
// Reset clears the sums, the sequencer and the output valid.
module cosine_similarity_stream (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [css_pkg::ELEM_W-1:0] elem_a,
	input  logic signed [css_pkg::ELEM_W-1:0] elem_b,
	input  logic                              last,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [css_pkg::SIM_W-1:0]  similarity,
	output logic                              zero_norm
);
	import css_pkg::*;

	logic signed [DOT_W-1:0] dot_q;
	logic [NORM_W-1:0]       na_q;
	logic [NORM_W-1:0]       nb_q;
	logic                    busy_q;
	logic                    out_valid_q;
	logic [SIM_W-1:0]        sim_q;
	logic                    zero_q;

	logic signed [2*ELEM_W-1:0] ab, aa, bb;
	logic signed [DOT_W-1:0]    dot_nx;
	logic [NORM_W-1:0]          na_nx;
	logic [NORM_W-1:0]          nb_nx;
	logic                       acc_in;
	logic                       is_zero;
	logic                       start;
	css_job_t                   job;
	logic                       eng_done;
	logic [SIM_W-1:0]           eng_sim;

	// Form the products and the new sums
	assign ab     = elem_a * elem_b;
	assign aa     = elem_a * elem_a;
	assign bb     = elem_b * elem_b;
	assign dot_nx = dot_q + DOT_W'(ab);
	assign na_nx  = na_q + NORM_W'(unsigned'(aa));
	assign nb_nx  = nb_q + NORM_W'(unsigned'(bb));

	assign in_ready = !busy_q && !(last && out_valid_q);
	assign acc_in   = in_valid && in_ready;
	assign is_zero  = (na_nx == '0) || (nb_nx == '0);
	assign start    = acc_in && last && !is_zero;

	assign job.dot    = dot_nx;
	assign job.norm_a = na_nx;
	assign job.norm_b = nb_nx;

	css_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.job    (job),
		.done   (eng_done),
		.sim    (eng_sim)
	);

	// Accumulate, clear on the last pair, hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q       <= '0;
			na_q        <= '0;
			nb_q        <= '0;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (acc_in) begin
				if (last) begin
					dot_q <= '0;
					na_q  <= '0;
					nb_q  <= '0;
					if (is_zero) begin
						out_valid_q <= 1'b1;
						sim_q       <= '0;
						zero_q      <= 1'b1;
					end else begin
						busy_q <= 1'b1;
					end
				end else begin
					dot_q <= dot_nx;
					na_q  <= na_nx;
					nb_q  <= nb_nx;
				end
			end
			if (eng_done) begin
				busy_q      <= 1'b0;
				out_valid_q <= 1'b1;
				sim_q       <= eng_sim;
				zero_q      <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign similarity = signed'(sim_q);
	assign zero_norm  = zero_q;
endmodule

[sv/css_engine.sv]
// Sequenced multiply, divide and square root engine that turns the sums into a Q1.15 similarity.
module css_engine (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  css_pkg::css_job_t            job,
	output logic                         done,
	output logic [css_pkg::SIM_W-1:0]    sim
);
	import css_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_MP, S_MR, S_CHK, S_DIV, S_SQ, S_FIN} state_t;

	state_t              state_q;
	logic [4:0]          cnt_q;
	logic [DOT_W-1:0]    mag_q;
	logic [DOT_W-1:0]    na_q;
	logic [DOT_W-1:0]    nb_q;
	logic                neg_q;
	logic [PROD_W-1:0]   acc_q;
	logic [P_W-1:0]      p_q;
	logic [P_W-1:0]      rem_q;
	logic [DIV_W-1:0]    dlo_q;
	logic [DIV_W-1:0]    d_q;
	logic [ROOT_W-1:0]   root_q;
	logic                done_q;
	logic [SIM_W-1:0]    sim_q;

	logic [MUL_W-1:0]    mx, my;
	logic [2*MUL_W-1:0]  mp;
	logic [PROD_W-1:0]   pp_sh;
	logic [PROD_W-1:0]   acc_nx;
	logic [ROOT_W-1:0]   trial;
	logic [3:0]          bit_idx;
	logic [P_W:0]        rs;
	logic [P_W:0]        p_ext;
	logic                ge;
	logic [P_W:0]        diff;
	logic [DOT_W-1:0]    mag_in;
	logic [ROOT_W-1:0]   q_sat;

	// Pick the operands of the shared multiplier by step
	assign bit_idx = ~cnt_q[3:0];
	assign trial   = root_q | (ROOT_W'(1) << bit_idx);

	always_comb begin
		unique case (state_q)
			S_MP: begin
				mx = cnt_q[1] ? na_q[DOT_W-1:MUL_W] : na_q[MUL_W-1:0];
				my = cnt_q[0] ? nb_q[DOT_W-1:MUL_W] : nb_q[MUL_W-1:0];
			end
			S_MR: begin
				mx = cnt_q[1] ? mag_q[DOT_W-1:MUL_W] : mag_q[MUL_W-1:0];
				my = cnt_q[0] ? mag_q[DOT_W-1:MUL_W] : mag_q[MUL_W-1:0];
			end
			S_SQ: begin
				mx = MUL_W'(trial);
				my = MUL_W'(trial);
			end
			default: begin
				mx = '0;
				my = '0;
			end
		endcase
	end

	assign mp = mx * my;

	// Weight the partial product by its place
	always_comb begin
		unique case (cnt_q[1:0])
			2'd0:    pp_sh = PROD_W'(mp);
			2'd3:    pp_sh = PROD_W'(mp) << (2 * MUL_W);
			default: pp_sh = PROD_W'(mp) << MUL_W;
		endcase
	end

	assign acc_nx = acc_q + pp_sh;

	// One restoring division step
	assign rs    = {rem_q, dlo_q[DIV_W-1]};
	assign p_ext = {1'b0, p_q};
	assign ge    = rs >= p_ext;
	assign diff  = rs - p_ext;

	assign mag_in = job.dot[DOT_W-1] ? DOT_W'(-job.dot) : DOT_W'(job.dot);

	// Clamp the root to the signed range
	always_comb begin
		if (neg_q) begin
			q_sat = (root_q > ROOT_W'(32768)) ? ROOT_W'(32768) : root_q;
		end else begin
			q_sat = (root_q > ROOT_W'(32767)) ? ROOT_W'(32767) : root_q;
		end
	end

	// Sequence the shared unit through multiply, divide and root
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						mag_q   <= mag_in;
						neg_q   <= job.dot[DOT_W-1];
						na_q    <= {1'b0, job.norm_a};
						nb_q    <= {1'b0, job.norm_b};
						acc_q   <= '0;
						cnt_q   <= '0;
						state_q <= S_MP;
					end
				end
				S_MP: begin
					acc_q <= acc_nx;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q[1:0] == 2'd3) begin
						p_q     <= acc_nx[P_W-1:0];
						acc_q   <= '0;
						cnt_q   <= '0;
						state_q <= S_MR;
					end
				end
				S_MR: begin
					acc_q <= acc_nx;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q[1:0] == 2'd3) begin
						rem_q   <= acc_nx[PROD_W-1:2];
						dlo_q   <= {acc_nx[1:0], 30'b0};
						cnt_q   <= '0;
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					root_q <= '0;
					cnt_q  <= '0;
					if (rem_q >= p_q) begin
						d_q     <= '1;
						state_q <= S_SQ;
					end else begin
						d_q     <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q <= ge ? diff[P_W-1:0] : rs[P_W-1:0];
					dlo_q <= {dlo_q[DIV_W-2:0], 1'b0};
					d_q   <= {d_q[DIV_W-2:0], ge};
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						cnt_q   <= '0;
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					if (mp <= (2*MUL_W)'(d_q)) begin
						root_q <= trial;
					end
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q[3:0] == 4'd15) begin
						cnt_q   <= '0;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					sim_q   <= neg_q ? SIM_W'(-q_sat) : SIM_W'(q_sat);
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign sim  = sim_q;
endmodule
